[rtl/rwng_pkg.sv]
// Shared types, widths and constants of the random walk noise generator.
// Every other file of the block imports this package; it depends on nothing.
package rwng_pkg;

   // tanh table geometry
   localparam int TANH_TABLE_DEPTH = 256;
   localparam int TBL_AW           = $clog2(TANH_TABLE_DEPTH);
   localparam int TBL_LAST         = TANH_TABLE_DEPTH - 1;
   localparam int TBL_W            = 16;

   // table abscissa in Q30 advances by 2^24 / (depth - 1) per entry
   localparam int A_W      = 25;
   localparam int A_STEP_Q = (1 << 24) / TBL_LAST;
   localparam int A_STEP_R = (1 << 24) % TBL_LAST;
   localparam int AREM_W   = TBL_AW + 1;

   // field and state widths
   localparam int DRAW_W     = 16;
   localparam int OUT_W      = 16;
   localparam int PHASE_W    = 24;
   localparam int GAIN_W     = 16;
   localparam int VEL_W      = 20;
   localparam int LEVEL_W    = 16;
   localparam int SMOOTH_W   = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // shared multiplier
   localparam int MUL_W  = 32;
   localparam int PROD_W = 64;

   // fixed-point constants
   localparam int ONE_Q15       = 32768;
   localparam int ONE_Q16       = 65536;
   localparam int KICK_Q16      = 19661;
   localparam int VEL_LIMIT     = 262144;
   localparam int TANH_IN_LIMIT = 131072;
   localparam int SMOOTH_MAX    = 8388607;
   localparam int SMOOTH_MIN    = -8388608;

   // rounded reciprocals for the small series terms: x/3 and x/15
   localparam int RECIP3  = 43691;
   localparam int RECIP15 = 34953;

   // angle doubling: long division, one quotient bit a cycle
   localparam int T_W       = 31;
   localparam int DIV_STEPS = 31;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int DBL_STEPS = 8;
   localparam int DBL_W     = $clog2(DBL_STEPS);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOMENTUM   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH     = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PHASE,
      ST_KICK,
      ST_PULL,
      ST_DAMP,
      ST_VEL,
      ST_POS,
      ST_X,
      ST_IDX,
      ST_ADDR,
      ST_LO,
      ST_HI,
      ST_INTERP,
      ST_LEVEL,
      ST_DIFF,
      ST_SMUL,
      ST_SMOOTH,
      ST_I_SQ,
      ST_I_CUBE,
      ST_I_FIFTH,
      ST_I_THIRD,
      ST_I_FIFT,
      ST_I_SERIES,
      ST_I_TSQ,
      ST_I_DIVSET,
      ST_I_DIV,
      ST_I_WRITE
   } state_type;

   typedef struct packed {
      logic                    load;
      logic signed [MUL_W-1:0] op_a;
      logic signed [MUL_W-1:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic           start;
      logic [T_W-1:0] dividend;
      logic [T_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic           busy;
      logic           done;
      logic [T_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic              we;
      logic [TBL_AW-1:0] addr;
      logic [TBL_W-1:0]  data;
   } tbl_wr_type;

endpackage

[rtl/rwng_if.sv]
// Request and response channel interfaces of the random walk noise generator.
// Depends on rwng_pkg for the payload widths.
interface rwng_req_if import rwng_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DRAW_W-1:0] random_draw;

   modport source (output valid, output random_draw, input ready);
   modport sink (input valid, input random_draw, output ready);
endinterface

interface rwng_rsp_if import rwng_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] smoothed_out;
   logic                    kicked;

   modport source (output valid, output smoothed_out, output kicked, input ready);
   modport sink (input valid, input smoothed_out, input kicked, output ready);
endinterface

[rtl/rwng_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on rwng_pkg for the request struct and widths.
module rwng_mul import rwng_pkg::*; (
   input  logic                     clock,
   input  mul_req_type              mul_req,
   output logic signed [PROD_W-1:0] product
);

   logic signed [PROD_W-1:0] product_ff;

   // hold the product until the sequencer issues the next operand pair
   always_ff @(posedge clock) begin
      if (mul_req.load) begin
         product_ff <= $signed(mul_req.op_a) * $signed(mul_req.op_b);
      end
   end

   assign product = product_ff;

endmodule

[rtl/rwng_div.sv]
// Restoring divider for the tanh angle doubling: one quotient bit per cycle.
// Depends on rwng_pkg; the dividend is the given value shifted up by 31 bits.
module rwng_div import rwng_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [T_W-1:0]       rem_ff, rem_in;
   logic [T_W-1:0]       quo_ff, quo_in;
   logic [T_W-1:0]       dvsr_ff, dvsr_in;
   logic [T_W:0]         shifted;
   logic                 fits;

   assign shifted = {rem_ff, 1'b0};
   assign fits    = shifted >= {1'b0, dvsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = div_req.dividend;
         quo_in  = '0;
         dvsr_in = div_req.divisor;
      end else if (busy_ff) begin
         // shift in a zero dividend bit, subtract where the divisor fits
         rem_in = fits ? T_W'(shifted - {1'b0, dvsr_ff}) : T_W'(shifted);
         quo_in = {quo_ff[T_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[rtl/rwng_tbl.sv]
// tanh sample memory: one write port, one read port with registered data.
// Depends on rwng_pkg for depth, widths and the write struct.
module rwng_tbl import rwng_pkg::*; (
   input  logic              clock,
   input  tbl_wr_type        tbl_wr,
   input  logic [TBL_AW-1:0] raddr,
   output logic [TBL_W-1:0]  rdata
);

   logic [TBL_W-1:0] mem [TANH_TABLE_DEPTH];
   logic [TBL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (tbl_wr.we) begin
         mem[tbl_wr.addr] <= tbl_wr.data;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/random_walk_noise_generator.sv]
// Random walk noise generator top level: sequencer over one shared multiplier.
// A request is taken only in the idle state, so the next one waits until the result
// has gone into the result register, which a stalled response channel holds up.
// Reset: synchronous; the tanh table is then rebuilt entry by entry,
// during which requests wait and configuration writes are taken. Uses rwng_pkg, rwng_if.
module random_walk_noise_generator import rwng_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rwng_req_if.sink              req_channel,
   rwng_rsp_if.source            rsp_channel,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam logic [T_W-1:0] DIV_BIAS = T_W'(1 << 30);

   state_type state_ff, state_in;

   // configuration
   logic [PHASE_W-1:0] phase_step_ff;
   logic [GAIN_W-1:0]  momentum_ff;
   logic [GAIN_W-1:0]  smooth_gain_ff;

   // architectural state
   logic [PHASE_W-1:0]         phase_acc_ff;
   logic signed [VEL_W-1:0]    velocity_ff;
   logic signed [LEVEL_W-1:0]  level_ff;
   logic signed [SMOOTH_W-1:0] smoothed_ff;

   // per-request working registers
   logic [DRAW_W-1:0]    draw_ff;
   logic                 kick_ff;
   logic signed [20:0]   acc_ff;
   logic [17:0]          mag_ff;
   logic                 neg_ff;
   logic [TBL_AW-1:0]    idx_ff;
   logic [16:0]          frac_ff;
   logic                 last_ff;
   logic [TBL_W-1:0]     lo_ff;
   logic signed [16:0]   diff_ff;
   logic signed [24:0]   delta_ff;

   // table build registers
   logic                 init_done_ff;
   logic [TBL_AW-1:0]    entry_ff;
   logic [A_W-1:0]       a_ff;
   logic [AREM_W-1:0]    arem_ff;
   logic [19:0]          a2_ff;
   logic [13:0]          a3_ff;
   logic [4:0]           a5x2_ff;
   logic [13:0]          a3d3_ff;
   logic [T_W-1:0]       t_ff;
   logic [DBL_W-1:0]     dbl_ff;

   // result register
   logic                    out_valid_ff;
   logic signed [OUT_W-1:0] out_smooth_ff;
   logic                    out_kick_ff;

   // shared units
   mul_req_type              mul_req;
   logic signed [PROD_W-1:0] p_ff;
   div_req_type              div_req;
   div_rsp_type              div_rsp;
   tbl_wr_type               tbl_wr;
   logic [TBL_AW-1:0]        tbl_raddr;
   logic [TBL_W-1:0]         tbl_rdata;
   logic                     req_ready;

   rwng_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (p_ff)
   );

   rwng_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   rwng_tbl u_tbl (
      .clock  (clock),
      .tbl_wr (tbl_wr),
      .raddr  (tbl_raddr),
      .rdata  (tbl_rdata)
   );

   // derived values
   logic [GAIN_W-1:0]          m_eff;
   logic [GAIN_W-1:0]          g_eff;
   logic [16:0]                damp_factor;
   logic [PHASE_W:0]           phase_sum;
   logic signed [17:0]         kick_base;
   logic signed [PROD_W-1:0]   p_rnd15, p_rnd16, p_rnd17, p_rnd24;
   logic signed [20:0]         x_sum, x_clamp;
   logic signed [VEL_W-1:0]    vel_clamp;
   logic signed [16:0]         y_val;
   logic signed [25:0]         s_sum;
   logic signed [SMOOTH_W-1:0] s_clamp;
   logic [TBL_W-1:0]           t_rnd;
   logic [AREM_W-1:0]          arem_sum;
   logic                       out_free;

   assign m_eff       = (momentum_ff > GAIN_W'(ONE_Q15)) ? GAIN_W'(ONE_Q15) : momentum_ff;
   assign g_eff       = (smooth_gain_ff > GAIN_W'(ONE_Q15)) ? GAIN_W'(ONE_Q15) : smooth_gain_ff;
   assign damp_factor = 17'(ONE_Q16) - 17'(m_eff);
   assign phase_sum   = {1'b0, phase_acc_ff} + {1'b0, phase_step_ff};
   assign kick_base   = $signed({1'b0, draw_ff, 1'b0}) - 18'sd65536;

   // round half up, then drop the fraction bits
   assign p_rnd15 = (p_ff + PROD_W'(1 << 14)) >>> 15;
   assign p_rnd16 = (p_ff + PROD_W'(1 << 15)) >>> 16;
   assign p_rnd17 = (p_ff + PROD_W'(1 << 16)) >>> 17;
   assign p_rnd24 = (p_ff + PROD_W'(1 << 23)) >>> 24;

   always_comb begin
      if (p_rnd16 > PROD_W'(VEL_LIMIT)) begin
         vel_clamp = VEL_W'(VEL_LIMIT);
      end else if (p_rnd16 < -PROD_W'(VEL_LIMIT)) begin
         vel_clamp = -VEL_W'(VEL_LIMIT);
      end else begin
         vel_clamp = VEL_W'(p_rnd16);
      end
   end

   assign x_sum = 21'(level_ff) + 21'(p_rnd24);

   always_comb begin
      if (x_sum > 21'(TANH_IN_LIMIT)) begin
         x_clamp = 21'(TANH_IN_LIMIT);
      end else if (x_sum < -21'(TANH_IN_LIMIT)) begin
         x_clamp = -21'(TANH_IN_LIMIT);
      end else begin
         x_clamp = x_sum;
      end
   end

   // past the last table point the last entry stands alone
   assign y_val = last_ff ? $signed({1'b0, lo_ff}) : $signed({1'b0, lo_ff}) + 17'(p_rnd17);

   assign s_sum = 26'(smoothed_ff) + 26'(p_rnd15);

   always_comb begin
      if (s_sum > 26'(SMOOTH_MAX)) begin
         s_clamp = SMOOTH_W'(SMOOTH_MAX);
      end else if (s_sum < 26'(SMOOTH_MIN)) begin
         s_clamp = SMOOTH_W'(SMOOTH_MIN);
      end else begin
         s_clamp = SMOOTH_W'(s_sum);
      end
   end

   assign t_rnd    = TBL_W'((32'(t_ff) + 32'd16384) >> 15);
   assign arem_sum = arem_ff + AREM_W'(A_STEP_R);
   assign out_free = !out_valid_ff || rsp_channel.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_channel.valid) state_in = ST_PHASE;
         ST_PHASE:    state_in = phase_sum[PHASE_W] ? ST_KICK : ST_POS;
         ST_KICK:     state_in = ST_PULL;
         ST_PULL:     state_in = ST_DAMP;
         ST_DAMP:     state_in = ST_VEL;
         ST_VEL:      state_in = ST_POS;
         ST_POS:      state_in = ST_X;
         ST_X:        state_in = ST_IDX;
         ST_IDX:      state_in = ST_ADDR;
         ST_ADDR:     state_in = ST_LO;
         ST_LO:       state_in = ST_HI;
         ST_HI:       state_in = ST_INTERP;
         ST_INTERP:   state_in = ST_LEVEL;
         ST_LEVEL:    state_in = ST_DIFF;
         ST_DIFF:     state_in = ST_SMUL;
         ST_SMUL:     state_in = ST_SMOOTH;
         ST_SMOOTH:   if (out_free) state_in = ST_IDLE;
         ST_I_SQ:     state_in = ST_I_CUBE;
         ST_I_CUBE:   state_in = ST_I_FIFTH;
         ST_I_FIFTH:  state_in = ST_I_THIRD;
         ST_I_THIRD:  state_in = ST_I_FIFT;
         ST_I_FIFT:   state_in = ST_I_SERIES;
         ST_I_SERIES: state_in = ST_I_TSQ;
         ST_I_TSQ:    state_in = ST_I_DIVSET;
         ST_I_DIVSET: state_in = ST_I_DIV;
         ST_I_DIV: begin
            if (div_rsp.done) begin
               state_in = (dbl_ff == DBL_W'(DBL_STEPS - 1)) ? ST_I_WRITE : ST_I_TSQ;
            end
         end
         ST_I_WRITE:  state_in = (entry_ff == TBL_AW'(TBL_LAST)) ? ST_IDLE : ST_I_SQ;
         default:     state_in = ST_IDLE;
      endcase
   end

   // unit control and operand selection
   always_comb begin
      mul_req          = '0;
      div_req.start    = 1'b0;
      div_req.dividend = t_ff;
      div_req.divisor  = DIV_BIAS + p_ff[60:30];
      tbl_wr.we        = 1'b0;
      tbl_wr.addr      = entry_ff;
      tbl_wr.data      = t_rnd;
      tbl_raddr        = idx_ff;
      req_ready        = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_PHASE: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(kick_base);
            mul_req.op_b = 32'(KICK_Q16);
         end
         ST_KICK: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(level_ff);
            mul_req.op_b = 32'(m_eff);
         end
         ST_DAMP: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(acc_ff);
            mul_req.op_b = 32'(damp_factor);
         end
         ST_POS: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(velocity_ff);
            mul_req.op_b = 32'(phase_step_ff);
         end
         ST_IDX: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(mag_ff);
            mul_req.op_b = 32'(TBL_LAST);
         end
         ST_ADDR: tbl_raddr = p_ff[16+TBL_AW:17];
         ST_LO:   tbl_raddr = last_ff ? idx_ff : idx_ff + 1'b1;
         ST_INTERP: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(diff_ff);
            mul_req.op_b = 32'(frac_ff);
         end
         ST_SMUL: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(delta_ff);
            mul_req.op_b = 32'(g_eff);
         end
         ST_I_SQ: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(a_ff);
            mul_req.op_b = 32'(a_ff);
         end
         ST_I_CUBE: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(p_ff[49:30]);
            mul_req.op_b = 32'(a_ff);
         end
         ST_I_FIFTH: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(p_ff[43:30]);
            mul_req.op_b = 32'(a2_ff);
         end
         ST_I_THIRD: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(a3_ff);
            mul_req.op_b = 32'(RECIP3);
         end
         ST_I_FIFT: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(a5x2_ff);
            mul_req.op_b = 32'(RECIP15);
         end
         ST_I_TSQ: begin
            mul_req.load = 1'b1;
            mul_req.op_a = 32'(t_ff);
            mul_req.op_b = 32'(t_ff);
         end
         ST_I_DIVSET: div_req.start = 1'b1;
         ST_I_WRITE:  tbl_wr.we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_I_SQ;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= PHASE_W'(349);
         momentum_ff    <= '0;
         smooth_gain_ff <= GAIN_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PHASE_STEP: phase_step_ff  <= csr_write_data;
            CSR_MOMENTUM:   momentum_ff    <= csr_write_data[GAIN_W-1:0];
            CSR_SMOOTH:     smooth_gain_ff <= csr_write_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // architectural state and table build control
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         velocity_ff  <= '0;
         level_ff     <= '0;
         smoothed_ff  <= '0;
         init_done_ff <= 1'b0;
         entry_ff     <= '0;
         a_ff         <= '0;
         arem_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_PHASE) begin
            phase_acc_ff <= phase_sum[PHASE_W-1:0];
         end
         if (state_ff == ST_VEL) begin
            velocity_ff <= vel_clamp;
         end
         if (state_ff == ST_LEVEL) begin
            level_ff <= LEVEL_W'(neg_ff ? -y_val : y_val);
         end
         if (state_ff == ST_SMOOTH && out_free) begin
            smoothed_ff  <= s_clamp;
            out_valid_ff <= 1'b1;
         end else if (rsp_channel.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == ST_I_WRITE) begin
            entry_ff <= entry_ff + 1'b1;
            // advance the abscissa by quotient and carried remainder
            if (arem_sum >= AREM_W'(TBL_LAST)) begin
               arem_ff <= arem_sum - AREM_W'(TBL_LAST);
               a_ff    <= a_ff + A_W'(A_STEP_Q + 1);
            end else begin
               arem_ff <= arem_sum;
               a_ff    <= a_ff + A_W'(A_STEP_Q);
            end
            if (entry_ff == TBL_AW'(TBL_LAST)) begin
               init_done_ff <= 1'b1;
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE:  if (req_channel.valid) draw_ff <= req_channel.random_draw;
         ST_PHASE: kick_ff <= phase_sum[PHASE_W];
         ST_KICK:  acc_ff <= 21'(velocity_ff) + 21'(p_rnd17);
         ST_PULL:  acc_ff <= acc_ff - 21'(p_rnd15);
         ST_X: begin
            neg_ff <= x_clamp < 0;
            mag_ff <= 18'((x_clamp < 0) ? -x_clamp : x_clamp);
         end
         ST_ADDR: begin
            idx_ff  <= p_ff[16+TBL_AW:17];
            frac_ff <= p_ff[16:0];
            last_ff <= p_ff[16+TBL_AW:17] == TBL_AW'(TBL_LAST);
         end
         ST_LO:   lo_ff <= tbl_rdata;
         ST_HI:   diff_ff <= $signed({1'b0, tbl_rdata}) - $signed({1'b0, lo_ff});
         ST_DIFF: delta_ff <= 25'($signed({level_ff, 8'd0})) - 25'(smoothed_ff);
         ST_SMOOTH: begin
            if (out_free) begin
               out_smooth_ff <= s_clamp[SMOOTH_W-1:SMOOTH_W-OUT_W];
               out_kick_ff   <= kick_ff;
            end
         end
         ST_I_CUBE:   a2_ff <= p_ff[49:30];
         ST_I_FIFTH:  a3_ff <= p_ff[43:30];
         ST_I_THIRD:  a5x2_ff <= {p_ff[33:30], 1'b0};
         ST_I_FIFT:   a3d3_ff <= p_ff[30:17];
         ST_I_SERIES: begin
            t_ff   <= T_W'(a_ff) - T_W'(a3d3_ff) + T_W'(p_ff[20:19]);
            dbl_ff <= '0;
         end
         ST_I_DIV: begin
            if (div_rsp.done) begin
               t_ff   <= div_rsp.quotient;
               dbl_ff <= dbl_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign req_channel.ready        = req_ready;
   assign rsp_channel.valid        = out_valid_ff;
   assign rsp_channel.smoothed_out = out_smooth_ff;
   assign rsp_channel.kicked       = out_kick_ff;

`ifndef SYNTHESIS
   a_no_request_during_build : assert property (@(posedge clock) disable iff (reset)
      !init_done_ff |-> !req_channel.ready)
      else $error("request accepted before tanh table build finished");

   a_stall_holds_smoother : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SMOOTH && out_valid_ff && !rsp_channel.ready)
      |=> (state_ff == ST_SMOOTH && $stable(smoothed_ff)))
      else $error("smoother advanced while result register was full");

   a_velocity_only_in_update : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(velocity_ff)) |-> $past(state_ff) == ST_VEL)
      else $error("velocity changed outside its update step");

   a_tanh_input_bounded : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDX |-> mag_ff <= 18'(TANH_IN_LIMIT))
      else $error("tanh input magnitude beyond limit");

   a_div_start_idle : assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for random_walk_noise_generator: a directed script, then random
// phases of register settings and draws, checked against an in-bench fixed-point walk model.
// Depends on rwng_pkg, the channel interfaces in rwng_if and the block's RTL.
module tb_top;
   import rwng_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int IDLE_LIMIT   = 300000;
   localparam int TAIL_CYCLES  = 40;
   localparam int RANDOM_TICKS = 680;
   localparam int PRINT_CAP    = 100;
   localparam int SCRIPT_ROWS  = 26;

   typedef enum logic {ROW_DRAW, ROW_WRITE} row_kind_t;
   typedef enum int {DRAW_UNIFORM, DRAW_HIGH, DRAW_LOW, DRAW_EXTREME} draw_mode_t;

   typedef struct packed {
      logic signed [OUT_W-1:0] level_out;
      logic                    kicked;
   } noise_sample_t;

   typedef struct packed {
      row_kind_t             kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
      logic [DRAW_W-1:0]     draw;
      logic                  pinned;
      noise_sample_t         sample;
   } script_row_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   logic                  req_pinned;
   noise_sample_t         req_pin_sample;

   rwng_req_if req_bus ();
   rwng_rsp_if rsp_bus ();

   random_walk_noise_generator uut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // walk model: registers, state and tanh points
   logic [PHASE_W-1:0] cfg_phase_step;
   logic [GAIN_W-1:0]  cfg_momentum;
   logic [GAIN_W-1:0]  cfg_smooth;
   logic [PHASE_W-1:0] walk_phase;
   int                 walk_velocity;
   int                 walk_level;
   int                 walk_smooth;
   int                 tanh_points [TANH_TABLE_DEPTH];

   noise_sample_t expected_samples [$];
   noise_sample_t got_sample;
   noise_sample_t want_sample;
   script_row_t   directed_rows [SCRIPT_ROWS];

   int   mismatch_count = 0;
   int   idle_cycles    = 0;
   int   burst_left     = 0;
   int   gap_len        = 0;
   bit   steady_sender  = 1'b0;
   int   stall_left     = 0;
   logic [31:0] stall_pattern;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic longint round_half_up(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clamp_to(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // tanh(4*i/(depth-1)) in Q1.15: short series, then eight angle doublings
   function automatic int tanh_point(longint unsigned i);
      longint unsigned a, a2, a3, a5, t, t2;
      a  = i * (64'd4 << 22) / TBL_LAST;
      a2 = (a * a) >> 30;
      a3 = (a2 * a) >> 30;
      a5 = (a3 * a2) >> 30;
      t  = a - a3 / 3 + (2 * a5) / 15;
      for (int k = 0; k < 8; k++) begin
         t2 = (t * t) >> 30;
         t  = (t << 31) / ((64'd1 << 30) + t2);
      end
      return int'((t + (64'd1 << 14)) >> 15);
   endfunction

   function automatic int tanh_interp(longint x);
      longint unsigned mag, pos, idx;
      longint          frac, lo, hi, y;
      mag  = (x < 0) ? -x : x;
      pos  = mag * TBL_LAST;
      idx  = pos >> 17;
      frac = pos & 64'h1FFFF;
      if (idx >= TBL_LAST) begin
         y = tanh_points[TBL_LAST];
      end else begin
         lo = tanh_points[idx];
         hi = tanh_points[idx + 1];
         y  = lo + round_half_up((hi - lo) * frac, 17);
      end
      return int'((x < 0) ? -y : y);
   endfunction

   // advance the walk by one tick and return the sample it produces
   function automatic noise_sample_t advance_walk(logic [DRAW_W-1:0] draw);
      longint            r, m, g, ps, v, x, s, d;
      logic [PHASE_W:0]  sum;
      noise_sample_t     res;
      r   = draw;
      m   = (cfg_momentum > ONE_Q15) ? ONE_Q15 : cfg_momentum;
      g   = (cfg_smooth > ONE_Q15) ? ONE_Q15 : cfg_smooth;
      ps  = cfg_phase_step;
      sum = walk_phase + cfg_phase_step;
      walk_phase = sum[PHASE_W-1:0];
      if (sum[PHASE_W]) begin
         v = walk_velocity;
         v = v + round_half_up((2 * r - ONE_Q16) * KICK_Q16, 17);
         v = v - round_half_up(longint'(walk_level) * m, 15);
         v = round_half_up(v * (ONE_Q16 - m), 16);
         walk_velocity = int'(clamp_to(v, -VEL_LIMIT, VEL_LIMIT));
      end
      x = walk_level + round_half_up(longint'(walk_velocity) * ps, 24);
      x = clamp_to(x, -TANH_IN_LIMIT, TANH_IN_LIMIT);
      walk_level = tanh_interp(x);
      d = longint'(walk_level) * 256 - walk_smooth;
      s = walk_smooth + round_half_up(g * d, 15);
      walk_smooth = int'(clamp_to(s, SMOOTH_MIN, SMOOTH_MAX));
      res.level_out = OUT_W'(walk_smooth >>> 8);
      res.kicked    = sum[PHASE_W];
      return res;
   endfunction

   task automatic flag_mismatch(input string what);
      if (mismatch_count < PRINT_CAP)
         $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   // hold requests back until every outstanding result is in
   task automatic settle_walk();
      if (expected_samples.size() != 0) begin
         req_bus.valid <= 1'b0;
         while (expected_samples.size() != 0)
            @(negedge clock);
      end
      burst_left = 0;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      settle_walk();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_draw(input logic [DRAW_W-1:0] draw, input logic pin,
                            input noise_sample_t pin_sample);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap_len    = steady_sender ? 0 : $urandom_range(0, 8);
         if (gap_len > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap_len) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.random_draw <= draw;
      req_pinned          <= pin;
      req_pin_sample      <= pin_sample;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // receiver: stall on a rotating 32-bit pattern, reloaded after each full rotation
   always @(negedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern = '1;
            1: stall_pattern = $urandom;
            2: stall_pattern = 32'hF0F0_3333;
            default: stall_pattern = $urandom & $urandom;
         endcase
         stall_left = 32;
      end
      rsp_bus.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
      stall_left--;
   end

   // scoreboard: retire results, predict accepted requests, track register writes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_samples.size() == 0) begin
               flag_mismatch($sformatf("result %0d/%0d with nothing outstanding",
                                       rsp_bus.smoothed_out, rsp_bus.kicked));
            end else begin
               want_sample = expected_samples.pop_front();
               if (rsp_bus.smoothed_out !== want_sample.level_out)
                  flag_mismatch($sformatf("smoothed_out %0d, expected %0d",
                                          rsp_bus.smoothed_out, want_sample.level_out));
               if (rsp_bus.kicked !== want_sample.kicked)
                  flag_mismatch($sformatf("kicked %b, expected %b",
                                          rsp_bus.kicked, want_sample.kicked));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            got_sample = advance_walk(req_bus.random_draw);
            expected_samples.push_back(req_pinned ? req_pin_sample : got_sample);
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PHASE_STEP: cfg_phase_step = csr_write_data[PHASE_W-1:0];
               CSR_MOMENTUM:   cfg_momentum   = csr_write_data[GAIN_W-1:0];
               CSR_SMOOTH:     cfg_smooth     = csr_write_data[GAIN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // watchdog: give up after a long stretch with no handshake at all
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("random_walk_noise_generator test failed");
         $finish;
      end
   end

   initial begin
      int                    sent_ticks;
      int                    phase_len;
      int                    gain;
      draw_mode_t            draw_mode;
      logic [DRAW_W-1:0]     draw;
      logic [CSR_DATA_W-1:0] reg_word;

      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_PHASE_STEP;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.random_draw = '0;
      req_pinned          = 1'b0;
      req_pin_sample      = '0;
      rsp_bus.ready       = 1'b0;

      cfg_phase_step = 24'd349;
      cfg_momentum   = '0;
      cfg_smooth     = 16'd1;
      walk_phase     = '0;
      walk_velocity  = 0;
      walk_level     = 0;
      walk_smooth    = 0;
      for (int i = 0; i < TANH_TABLE_DEPTH; i++)
         tanh_points[i] = tanh_point(i);

      // right after reset the walk sits at zero until the first wrap
      directed_rows = '{
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'h0000, 1'b1, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'hFFFF, 1'b1, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'h8000, 1'b1, '0},
         '{ROW_WRITE, CSR_UNUSED,     24'hFFFFFF, 16'h0000, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'h5A5A, 1'b1, '0},
         '{ROW_WRITE, CSR_PHASE_STEP, 24'hFFFFFF, 16'h0000, 1'b0, '0},
         '{ROW_WRITE, CSR_SMOOTH,     24'h008000, 16'h0000, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'hFFFF, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'hFFFF, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'hFFFF, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'hFFFF, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'h0000, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'h0000, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'h0000, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'h8000, 1'b0, '0},
         '{ROW_WRITE, CSR_MOMENTUM,   24'h00FFFF, 16'h0000, 1'b0, '0},
         '{ROW_WRITE, CSR_SMOOTH,     24'h00FFFF, 16'h0000, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'hFFFF, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'h0000, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'h7FFF, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'h8001, 1'b0, '0},
         '{ROW_WRITE, CSR_MOMENTUM,   24'hFF4000, 16'h0000, 1'b0, '0},
         '{ROW_WRITE, CSR_SMOOTH,     24'h000000, 16'h0000, 1'b0, '0},
         '{ROW_WRITE, CSR_PHASE_STEP, 24'h000000, 16'h0000, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'hFFFF, 1'b0, '0},
         '{ROW_DRAW,  CSR_UNUSED,     24'h000000, 16'h0000, 1'b0, '0}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_WRITE)
            write_register(directed_rows[k].index, directed_rows[k].value);
         else
            send_draw(directed_rows[k].draw, directed_rows[k].pinned,
                      directed_rows[k].sample);
      end

      sent_ticks = 0;
      while (sent_ticks < RANDOM_TICKS) begin
         settle_walk();
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0: reg_word = '0;
               1: reg_word = 24'hFFFFFF;
               2: reg_word = $urandom_range(1, 4096);
               3: reg_word = 24'h800000;
               default: reg_word = $urandom & 24'hFFFFFF;
            endcase
            write_register(CSR_PHASE_STEP, reg_word);
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
               0: gain = 0;
               1: gain = ONE_Q15;
               2: gain = $urandom_range(ONE_Q15 + 1, 65535);
               default: gain = $urandom_range(0, ONE_Q15);
            endcase
            write_register(CSR_MOMENTUM, {8'($urandom), 16'(gain)});
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
               0: gain = 0;
               1: gain = ONE_Q15;
               2: gain = $urandom_range(ONE_Q15 + 1, 65535);
               3: gain = $urandom_range(1, 512);
               default: gain = $urandom_range(0, ONE_Q15);
            endcase
            write_register(CSR_SMOOTH, {8'($urandom), 16'(gain)});
         end
         if ($urandom_range(0, 7) == 0)
            write_register(CSR_UNUSED, 24'($urandom));

         steady_sender = ($urandom_range(0, 3) == 0);
         draw_mode     = draw_mode_t'($urandom_range(0, 3));
         phase_len     = $urandom_range(15, 70);
         for (int k = 0; k < phase_len; k++) begin
            case (draw_mode)
               DRAW_UNIFORM: draw = 16'($urandom);
               DRAW_HIGH:    draw = 16'($urandom_range(16'hC000, 16'hFFFF));
               DRAW_LOW:     draw = 16'($urandom_range(0, 16'h3FFF));
               default:      draw = ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                    ^ 16'($urandom_range(0, 1));
            endcase
            send_draw(draw, 1'b0, '0);
            sent_ticks++;
         end
      end

      settle_walk();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_samples.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", expected_samples.size()));
      if (mismatch_count == 0)
         $display("random_walk_noise_generator test passed");
      else
         $display("random_walk_noise_generator test failed");
      $finish;
   end

endmodule
